// ===== design/hbwd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbwd_pkg
// Shared types and constants for the heartbeat watchdog.
// ----------------------------------------------------------------------------
package hbwd_pkg;

    localparam int SILENCE_W = 16;
    localparam int CONFIRM_W = 8;
    localparam int INDEX_W   = 4;
    localparam int MASK_BITS = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SILENCE_W-1:0] SILENCE_MAX = 16'hFFFF;
    localparam logic [CONFIRM_W-1:0] CONFIRM_MAX = 8'hFF;

    localparam logic [SILENCE_W-1:0] TIMEOUT_RESET = 16'd15;
    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS = 1'b1;

    // item kinds
    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_HEARTBEAT = 1'b1;

    // per-channel control for one item
    typedef struct packed {
        logic tick;
        logic heartbeat;
    } chan_ctl_t;

    // per-channel status after an item
    typedef struct packed {
        logic timed_out;
        logic confirmed;
        logic led;
    } chan_stat_t;

endpackage

// ===== design/multi_channel_heartbeat_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_unit
// Heartbeat watchdog over CHANNELS channels with timeout confirmation.
// ----------------------------------------------------------------------------
// Each accepted item is either a monitor tick (advances every unlatched
// channel's saturating silence counter, flags a timeout and lights the LED
// when timeout_ticks is reached, then latches the fault as confirmed when its
// confirm count, which includes the detecting tick, reaches confirm_ticks) or
// a heartbeat for ecu_index (clears that channel's silence counter, timeout
// flag and confirm counter; the confirmed latch and LED stay set until reset;
// an index at or above CHANNELS changes nothing). Every item yields exactly
// one result carrying the state after that item. Throughput is one item per
// clock unless out_stall holds the output register: the item is held in an
// input register, all channels update in parallel, and the masks land in an
// output register, whose load raises out_valid. in_stall rises only when the
// output register is full and held by out_stall. Only channels 0..2 appear
// in the masks; any_confirmed covers all channels. Configuration is written
// through cfg_write/cfg_index/cfg_data while idle; reset values are
// timeout_ticks = 15, confirm_ticks = 5.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_unit
    import hbwd_pkg::*;
#(
    parameter int CHANNELS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic [INDEX_W-1:0]    ecu_index,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [MASK_BITS-1:0]  timed_out_mask,
    output logic [MASK_BITS-1:0]  confirmed_mask,
    output logic [MASK_BITS-1:0]  led_mask,
    output logic                  any_confirmed
);

    // configuration registers
    logic [SILENCE_W-1:0] timeout_ticks_reg;
    logic [CONFIRM_W-1:0] confirm_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
            confirm_ticks_reg <= CONFIRM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[SILENCE_W-1:0];
                REG_CONFIRM_TICKS: confirm_ticks_reg <= cfg_data[CONFIRM_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    logic               in_valid_reg;
    logic               action_reg;
    logic [INDEX_W-1:0] index_reg;
    logic               advance;
    logic               in_accept;

    // item moves into the output register when there is room there
    assign advance   = in_valid_reg && (!out_valid || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            index_reg  <= ecu_index;
        end
    end

    // channel cells, all updated together
    chan_stat_t          stat_next [CHANNELS];
    logic [CHANNELS-1:0] conf_next;
    logic [CHANNELS-1:0] conf_state;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        chan_ctl_t ctl;

        assign ctl.tick      = (action_reg == ACT_TICK);
        assign ctl.heartbeat = (action_reg == ACT_HEARTBEAT)
                               && (index_reg == INDEX_W'(c));

        hbwd_chan u_chan
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .step          (advance),
            .ctl           (ctl),
            .timeout_ticks (timeout_ticks_reg),
            .confirm_ticks (confirm_ticks_reg),
            .stat_next     (stat_next[c]),
            .confirmed     (conf_state[c])
        );

        assign conf_next[c] = stat_next[c].confirmed;
    end

    // masks show the low channels only; missing channels read as zero
    logic [MASK_BITS-1:0] tmask_next, cmask_next, lmask_next;

    for (genvar m = 0; m < MASK_BITS; m++)
    begin : g_mask
        if (m < CHANNELS)
        begin : g_live
            assign tmask_next[m] = stat_next[m].timed_out;
            assign cmask_next[m] = stat_next[m].confirmed;
            assign lmask_next[m] = stat_next[m].led;
        end
        else
        begin : g_none
            assign tmask_next[m] = 1'b0;
            assign cmask_next[m] = 1'b0;
            assign lmask_next[m] = 1'b0;
        end
    end

    // output register
    logic                 out_valid_reg;
    logic [MASK_BITS-1:0] tmask_reg, cmask_reg, lmask_reg;
    logic                 any_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tmask_reg <= tmask_next;
            cmask_reg <= cmask_next;
            lmask_reg <= lmask_next;
            any_reg   <= |conf_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign timed_out_mask = tmask_reg;
    assign confirmed_mask = cmask_reg;
    assign led_mask       = lmask_reg;
    assign any_confirmed  = any_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a confirmed latch never drops before reset
    a_latch_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        (($past(conf_state) & ~conf_state) == '0))
        else $error("confirmed latch cleared");

    // confirmation and timeout both imply the LED is lit
    a_led_covers : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((confirmed_mask | timed_out_mask) & ~led_mask) == '0))
        else $error("fault without LED");

    // any_confirmed covers every confirmed bit in the mask
    a_any_conf : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (confirmed_mask != '0)) |-> any_confirmed)
        else $error("any_confirmed missing");

endmodule

// ===== design/hbwd_chan.sv =====
// ----------------------------------------------------------------------------
// hbwd_chan
// One watchdog channel: silence and confirm counters, flags and LED.
// ----------------------------------------------------------------------------
module hbwd_chan
    import hbwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  chan_ctl_t            ctl,
    input  logic [SILENCE_W-1:0] timeout_ticks,
    input  logic [CONFIRM_W-1:0] confirm_ticks,
    output chan_stat_t           stat_next,
    output logic                 confirmed
);

    logic [SILENCE_W-1:0] silence_reg, silence_next;
    logic [CONFIRM_W-1:0] confirm_reg, confirm_next;
    logic                 flag_reg, flag_next;
    logic                 latch_reg, latch_next;
    logic                 led_reg, led_next;

    logic [SILENCE_W-1:0] silence_inc;
    logic [CONFIRM_W-1:0] confirm_base;
    logic [CONFIRM_W-1:0] confirm_inc;

    assign silence_inc  = (silence_reg == SILENCE_MAX) ? silence_reg
                                                       : silence_reg + 16'd1;
    // confirm count restarts from zero on first detection
    assign confirm_base = flag_reg ? confirm_reg : '0;
    assign confirm_inc  = (confirm_base == CONFIRM_MAX) ? confirm_base
                                                        : confirm_base + 8'd1;

    always_comb
    begin
        silence_next = silence_reg;
        confirm_next = confirm_reg;
        flag_next    = flag_reg;
        latch_next   = latch_reg;
        led_next     = led_reg;
        if (ctl.tick)
        begin
            if (!latch_reg)
            begin
                silence_next = silence_inc;
                if (silence_inc >= timeout_ticks)
                begin
                    flag_next    = 1'b1;
                    led_next     = 1'b1;
                    confirm_next = confirm_inc;
                    if (confirm_inc >= confirm_ticks)
                    begin
                        latch_next = 1'b1;
                    end
                end
            end
        end
        else if (ctl.heartbeat)
        begin
            // latch and LED are sticky
            silence_next = '0;
            confirm_next = '0;
            flag_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg <= '0;
            confirm_reg <= '0;
            flag_reg    <= 1'b0;
            latch_reg   <= 1'b0;
            led_reg     <= 1'b0;
        end
        else if (step)
        begin
            silence_reg <= silence_next;
            confirm_reg <= confirm_next;
            flag_reg    <= flag_next;
            latch_reg   <= latch_next;
            led_reg     <= led_next;
        end
    end

    assign stat_next.timed_out = flag_next;
    assign stat_next.confirmed = latch_next;
    assign stat_next.led       = led_next;
    assign confirmed           = latch_reg;

endmodule

// ===== sim/hbwd_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// hbwd_tb_pkg
// Status prediction and result scoreboard for the heartbeat watchdog bench.
// ----------------------------------------------------------------------------
package hbwd_tb_pkg;

    import hbwd_pkg::*;

    localparam int WD_CHANNELS = 3;
    localparam int MAX_REPORTS = 100;

    // status of all channels after one item, as seen on the result port
    typedef struct packed {
        logic [MASK_BITS-1:0] timed_out;
        logic [MASK_BITS-1:0] confirmed;
        logic [MASK_BITS-1:0] led;
        logic                 any_confirmed;
    } wd_status_t;

    class heartbeat_scoreboard;

        logic [SILENCE_W-1:0] timeout_ticks;
        logic [CONFIRM_W-1:0] confirm_ticks;

        logic [SILENCE_W-1:0] silence   [WD_CHANNELS];
        logic [CONFIRM_W-1:0] confirm_cnt [WD_CHANNELS];
        bit                   timed_out [WD_CHANNELS];
        bit                   latched   [WD_CHANNELS];
        bit                   led_on    [WD_CHANNELS];

        wd_status_t expected_status_q [$];
        int         errors;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            confirm_ticks = CONFIRM_RESET;
            foreach (silence[c])
            begin
                silence[c]     = '0;
                confirm_cnt[c] = '0;
                timed_out[c]   = 1'b0;
                latched[c]     = 1'b0;
                led_on[c]      = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TIMEOUT_TICKS)
                timeout_ticks = data[SILENCE_W-1:0];
            else if (idx == REG_CONFIRM_TICKS)
                confirm_ticks = data[CONFIRM_W-1:0];
        endfunction

        // one monitor tick: latched channels stay frozen
        function void tick_channels();
            int c;
            for (c = 0; c < WD_CHANNELS; c++)
            begin
                if (latched[c])
                    continue;
                if (silence[c] != SILENCE_MAX)
                    silence[c]++;
                if (silence[c] >= timeout_ticks)
                begin
                    if (!timed_out[c])
                    begin
                        timed_out[c]   = 1'b1;
                        confirm_cnt[c] = '0;
                        led_on[c]      = 1'b1;
                    end
                    if (confirm_cnt[c] != CONFIRM_MAX)
                        confirm_cnt[c]++;
                    if (confirm_cnt[c] >= confirm_ticks)
                        latched[c] = 1'b1;
                end
            end
        endfunction

        // apply an accepted item and queue the status it must produce
        function void note_item(logic act, logic [INDEX_W-1:0] idx);
            wd_status_t st;
            int         c;
            st = '0;
            if (act == ACT_TICK)
                tick_channels();
            else if (idx < WD_CHANNELS)
            begin
                silence[idx]     = '0;
                timed_out[idx]   = 1'b0;
                confirm_cnt[idx] = '0;
            end
            for (c = 0; c < WD_CHANNELS; c++)
            begin
                if (latched[c])
                    st.any_confirmed = 1'b1;
                if (c < MASK_BITS)
                begin
                    st.timed_out[c] = timed_out[c];
                    st.confirmed[c] = latched[c];
                    st.led[c]       = led_on[c];
                end
            end
            expected_status_q.push_back(st);
        endfunction

        function void compare_field(string name, logic [MASK_BITS-1:0] want,
                                    logic [MASK_BITS-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(logic [MASK_BITS-1:0] tmask, logic [MASK_BITS-1:0] cmask,
                                   logic [MASK_BITS-1:0] lmask, logic anyc);
            wd_status_t want;
            if (expected_status_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result with no item outstanding: timed_out_mask %0h", tmask);
                return;
            end
            want = expected_status_q.pop_front();
            compare_field("timed_out_mask", want.timed_out, tmask);
            compare_field("confirmed_mask", want.confirmed, cmask);
            compare_field("led_mask", want.led, lmask);
            compare_field("any_confirmed", MASK_BITS'(want.any_confirmed), MASK_BITS'(anyc));
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

    endclass

endpackage

// ===== sim/tb_multi_channel_heartbeat_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// tb_multi_channel_heartbeat_watchdog_unit
// Self-checking bench for the multi-channel heartbeat watchdog.
// ----------------------------------------------------------------------------
// Ticks and heartbeats are pushed through the valid/stall input channel while
// a scoreboard predicts the channel status after every accepted item and
// checks each result in order. The run walks through several register
// settings (reset values, zero thresholds, the 16-bit timeout ceiling,
// confirmation at 255) and several idling mixes, with one long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_multi_channel_heartbeat_watchdog_unit
    import hbwd_pkg::*, hbwd_tb_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  action;
    logic [INDEX_W-1:0]    ecu_index;
    logic                  out_valid;
    logic                  out_stall;
    logic [MASK_BITS-1:0]  timed_out_mask;
    logic [MASK_BITS-1:0]  confirmed_mask;
    logic [MASK_BITS-1:0]  led_mask;
    logic                  any_confirmed;

    // idling odds in percent, and the long receiver hold-off
    int idle_pct;
    int stall_pct;
    bit hold_on;

    heartbeat_scoreboard sb;

    multi_channel_heartbeat_watchdog_unit #(
        .CHANNELS (WD_CHANNELS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .ecu_index      (ecu_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .timed_out_mask (timed_out_mask),
        .confirmed_mask (confirmed_mask),
        .led_mask       (led_mask),
        .any_confirmed  (any_confirmed)
    );

    always #2 clk = ~clk;

    // receiver: stall chosen at the falling edge, hold-off overrides it
    always @(negedge clk)
        out_stall <= hold_on || ($urandom_range(99) < stall_pct);

    // results are taken at the rising edge they are accepted on
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(timed_out_mask, confirmed_mask, led_mask, any_confirmed);
    end

    // Offer one item; called at a falling edge, returns at a falling edge.
    // While the sender idles the payload wanders, since the block must ignore it.
    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid  <= 1'b0;
            action    <= 1'($urandom_range(1));
            ecu_index <= INDEX_W'($urandom_range(15));
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        ecu_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(act, idx);
        @(negedge clk);
    endtask

    task automatic send_heartbeat(input int ch);
        send_item(ACT_HEARTBEAT, INDEX_W'(ch));
    endtask

    // ticks carry a random index, which must not matter
    task automatic send_ticks(input int n);
        repeat (n)
            send_item(ACT_TICK, INDEX_W'($urandom_range(15)));
    endtask

    // Indexes mostly name real channels, some out of range; hb_pct sets the heartbeat share.
    task automatic run_random(input int n, input int hb_pct);
        logic               act;
        logic [INDEX_W-1:0] idx;
        repeat (n)
        begin
            act = ($urandom_range(99) < hb_pct) ? ACT_HEARTBEAT : ACT_TICK;
            if ($urandom_range(9) < 8)
                idx = INDEX_W'($urandom_range(WD_CHANNELS - 1));
            else
                idx = INDEX_W'($urandom_range(15));
            send_item(act, idx);
        end
    endtask

    // Drop valid and wait until every result is back, plus the pipeline depth.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        sb.set_reg(idx, data);
    endtask

    // confirm data carries junk in the upper byte, which the block drops
    task automatic configure(input int tmo, input int cnf);
        settle();
        write_reg(REG_TIMEOUT_TICKS, SILENCE_W'(tmo));
        write_reg(REG_CONFIRM_TICKS, {8'($urandom_range(255)), CONFIRM_W'(cnf)});
    endtask

    task automatic set_idling(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_TIMEOUT_TICKS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = ACT_TICK;
        ecu_index = '0;
        out_stall = 1'b0;
        hold_on   = 1'b0;
        set_idling(0, 0);

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: reset settings, in-range and out-of-range indexes, first timeouts
        send_ticks(2);
        send_heartbeat(0);
        send_heartbeat(1);
        send_heartbeat(2);
        send_heartbeat(3);     // out of range
        send_heartbeat(15);
        send_heartbeat(8);
        configure(2, 255);
        send_ticks(3);         // all three time out, LEDs come on
        send_heartbeat(1);     // clears flag, LED stays
        send_ticks(1);
        send_heartbeat(0);
        send_heartbeat(2);
        send_heartbeat(9);
        send_ticks(2);

        // --- random, no idling
        configure(3, 255);
        run_random(200, 50);

        // --- zero timeout: every tick times a channel out at once
        configure(0, 255);
        set_idling(75, 0);
        run_random(200, 55);

        configure($urandom_range(1, 6), 200);
        set_idling(0, 75);
        run_random(200, 50);

        configure(4, 254);
        set_idling(27, 27);
        run_random(200, 50);

        // --- back-pressure: receiver holds off while items keep coming
        configure(2, 255);
        set_idling(0, 0);
        fork
            run_random(120, 60);
            begin
                repeat (10)
                    @(posedge clk);
                hold_on = 1'b1;
                repeat (200)
                    @(posedge clk);
                hold_on = 1'b0;
            end
        join

        // --- timeout ceiling: no channel times out
        configure(16'hFFFF, 255);
        send_heartbeat(0);
        send_heartbeat(1);
        send_heartbeat(2);
        send_ticks(40);
        send_heartbeat(0);

        // --- confirmation at 255 on channel 2, others kept alive
        configure(1, 255);
        send_heartbeat(0);
        send_heartbeat(1);
        send_heartbeat(2);
        repeat (26)
        begin
            send_ticks(10);
            send_heartbeat(0);
            send_heartbeat(1);
        end
        send_heartbeat(2);     // after confirmation: latch and LED stay

        // channel 1 latches with small thresholds
        configure(2, 3);
        repeat (4)
        begin
            send_ticks(2);
            send_heartbeat(0);
        end
        set_idling(27, 27);
        run_random(150, 50);

        // --- zero thresholds: the next tick confirms whatever is left
        configure(0, 0);
        send_ticks(1);
        run_random(30, 50);

        settle();
        repeat (8)
            @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog on the bench itself
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
